### design/assert_macros.svh
// Assertion macros shared by the lexer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### design/cll_pkg.sv
// ----------------------------------------------------------------------------
// cll_pkg
// Types, token codes and character helpers for the streaming lexer.
// ----------------------------------------------------------------------------
`default_nettype none
package cll_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int SPAN_W          = 24;
    localparam int VAL_W           = 63;
    localparam int KIND_W          = 6;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_AT, M_BUILTIN, M_STRING, M_ZERO, M_ZERO_X,
        M_HEX, M_DEC, M_FLOAT, M_OP, M_SHIFT
    } lex_mode_t;

    typedef enum logic [5:0] {
        K_ERROR, K_IDENT, K_BUILTIN, K_STRING, K_INT, K_FLOAT,
        K_LCURLY, K_RCURLY, K_LBRACKET, K_RBRACKET, K_LPAREN, K_RPAREN,
        K_ADD, K_SUB, K_MUL, K_DIV, K_MOD, K_ADDADD, K_SUBSUB,
        K_BITOR, K_BITXOR, K_BITAND, K_BITNOT, K_LSHIFT, K_RSHIFT,
        K_DOT, K_COMMA, K_QUESTION, K_COLON, K_SEMICOLON, K_NOT, K_ASSIGN,
        K_EQ, K_NOTEQ, K_LESS, K_LESSEQ, K_GREATER, K_GREATEREQ,
        K_ADD_ASSIGN, K_SUB_ASSIGN, K_MUL_ASSIGN, K_DIV_ASSIGN, K_MOD_ASSIGN,
        K_BITAND_ASSIGN, K_BITOR_ASSIGN, K_BITXOR_ASSIGN, K_BITNOT_ASSIGN,
        K_LSHIFT_ASSIGN, K_RSHIFT_ASSIGN, K_AND, K_OR, K_EOF
    } kind_t;

    typedef enum logic [1:0] {
        E_NONE    = 2'd0,
        E_UNCLOSED = 2'd1,
        E_UNKNOWN = 2'd2
    } err_t;

    typedef struct packed {
        logic [KIND_W-1:0] token_kind;
        logic [SPAN_W-1:0] start_offset;
        logic [SPAN_W-1:0] span_length;
        logic [VAL_W-1:0]  int_value;
        logic [1:0]        error_kind;
        logic [7:0]        bad_char;
        logic              last_of_run;
    } token_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } text_t;

    localparam logic [VAL_W-1:0] VALUE_MAX = {VAL_W{1'b1}};
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        if (is_digit(c)) d = c - 8'h30;
        else if (c >= 8'h61) d = c - 8'h57;
        else d = c - 8'h37;
        return d[3:0];
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        case (c)
            "=", "+", "-", "*", "/", "%", "|", "&", "^", "~", "!", "<", ">": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Kind of a bracket or punctuation byte, K_ERROR if none
    function automatic kind_t punct_kind(input logic [7:0] c);
        case (c)
            "{": return K_LCURLY;    "}": return K_RCURLY;
            "[": return K_LBRACKET;  "]": return K_RBRACKET;
            "(": return K_LPAREN;    ")": return K_RPAREN;
            ":": return K_COLON;     ";": return K_SEMICOLON;
            ".": return K_DOT;       ",": return K_COMMA;
            "?": return K_QUESTION;
            default: return K_ERROR;
        endcase
    endfunction

    function automatic kind_t single_kind(input logic [7:0] op);
        case (op)
            "=": return K_ASSIGN;  "+": return K_ADD;    "-": return K_SUB;
            "*": return K_MUL;     "/": return K_DIV;    "%": return K_MOD;
            "|": return K_BITOR;   "&": return K_BITAND; "^": return K_BITXOR;
            "~": return K_BITNOT;  "!": return K_NOT;    "<": return K_LESS;
            default: return K_GREATER;
        endcase
    endfunction

    function automatic kind_t assign_kind(input logic [7:0] op);
        case (op)
            "=": return K_EQ;            "+": return K_ADD_ASSIGN;
            "-": return K_SUB_ASSIGN;    "*": return K_MUL_ASSIGN;
            "/": return K_DIV_ASSIGN;    "%": return K_MOD_ASSIGN;
            "|": return K_BITOR_ASSIGN;  "&": return K_BITAND_ASSIGN;
            "^": return K_BITXOR_ASSIGN; "~": return K_BITNOT_ASSIGN;
            "!": return K_NOTEQ;         "<": return K_LESSEQ;
            default: return K_GREATEREQ;
        endcase
    endfunction

endpackage
`default_nettype wire

### design/cll_if.sv
// ----------------------------------------------------------------------------
// cll_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface cll_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/c_like_lexer.sv
// ----------------------------------------------------------------------------
// c_like_lexer
// Streaming tokenizer: one source byte per beat, up to three tokens out.
// ----------------------------------------------------------------------------
// The lexer takes one text beat per clock when its token queue has room for
// the three tokens a beat can produce at most; each beat's state update is
// combinational classification logic, so a steady stream runs at one byte
// per cycle as long as the sink takes tokens about as fast as they arise.
// Tokens leave through a four-entry register queue, one token per cycle
// while the sink is ready; a beat's two or three tokens leave one by one.
`default_nettype none
module c_like_lexer
    import cll_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    cll_if.sink      text_in,
    cll_if.source    token_out
);
`include "assert_macros.svh"

    localparam int QD = 4;

    lex_mode_t              mode_reg, mode_next;
    logic [7:0]             held_reg, held_next;
    logic [OFFSET_BITS-1:0] boff_reg, boff_next;
    logic [OFFSET_BITS-1:0] tstart_reg, tstart_next;
    logic [SPAN_W-1:0]      tspan_reg, tspan_next;
    logic [VAL_W-1:0]       acc_reg, acc_next;
    token_t                 tok [3];
    logic [1:0]             cnt;
    text_t                  beat;

    token_t     q_reg [QD];
    logic [1:0] rd_reg, wr_reg;
    logic [2:0] fill_reg;
    logic       take, pop;

    assign beat = text_in.data;

    cll_step #(.OFFSET_BITS(OFFSET_BITS)) u_step (
        .c(beat.text_byte), .eot(beat.end_of_text), .mode(mode_reg), .held(held_reg),
        .boff(boff_reg), .tstart(tstart_reg), .tspan(tspan_reg), .acc(acc_reg),
        .mode_next(mode_next), .held_next(held_next), .boff_next(boff_next),
        .tstart_next(tstart_next), .tspan_next(tspan_next), .acc_next(acc_next),
        .tok(tok), .count(cnt)
    );

    // Accept when three free slots remain after this cycle's pop
    assign text_in.ready   = (fill_reg <= 3'd1) || (fill_reg == 3'd2 && pop);
    assign take            = text_in.valid && text_in.ready;
    assign token_out.valid = fill_reg != 3'd0;
    assign token_out.data  = q_reg[rd_reg];
    assign pop             = token_out.valid && token_out.ready;

    // Lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            held_reg   <= '0;
            boff_reg   <= '0;
            tstart_reg <= '0;
            tspan_reg  <= '0;
            acc_reg    <= '0;
        end
        else if (take)
        begin
            mode_reg   <= mode_next;
            held_reg   <= held_next;
            boff_reg   <= boff_next;
            tstart_reg <= tstart_next;
            tspan_reg  <= tspan_next;
            acc_reg    <= acc_next;
        end
    end

    // Token queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg   <= '0;
            wr_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (pop) rd_reg <= rd_reg + 2'd1;
            if (take) wr_reg <= wr_reg + cnt;
            fill_reg <= fill_reg + (take ? {1'b0, cnt} : 3'd0) - (pop ? 3'd1 : 3'd0);
        end
    end

    // Token queue storage
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) < cnt) q_reg[wr_reg + 2'(i)] <= tok[i];
            end
        end
    end

    `ASSERT_IMPLY(a_fill_max, clk, rst_n, 1'b1, fill_reg <= 3'd4, "queue overflow")
    `ASSERT_IMPLY(a_eot_emits, clk, rst_n, take && beat.end_of_text, cnt != 2'd0,
                  "end of text without EOF token")
    `ASSERT_NEXT(a_eot_clears, clk, rst_n, take && beat.end_of_text,
                 mode_reg == M_IDLE && boff_reg == '0, "state not cleared after end")

endmodule
`default_nettype wire

### design/cll_step.sv
// ----------------------------------------------------------------------------
// cll_step
// One byte of lexing: next state and up to three tokens from the current state.
// ----------------------------------------------------------------------------
`default_nettype none
module cll_step
    import cll_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic [7:0]             c,
    input  wire logic                   eot,
    input  wire lex_mode_t              mode,
    input  wire logic [7:0]             held,
    input  wire logic [OFFSET_BITS-1:0] boff,
    input  wire logic [OFFSET_BITS-1:0] tstart,
    input  wire logic [SPAN_W-1:0]      tspan,
    input  wire logic [VAL_W-1:0]       acc,
    output lex_mode_t                   mode_next,
    output logic [7:0]                  held_next,
    output logic [OFFSET_BITS-1:0]      boff_next,
    output logic [OFFSET_BITS-1:0]      tstart_next,
    output logic [SPAN_W-1:0]           tspan_next,
    output logic [VAL_W-1:0]            acc_next,
    output token_t                      tok [3],
    output logic [1:0]                  count
);

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

    function automatic logic [SPAN_W-1:0] clip(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS+SPAN_W-1:0] w;
        w = {{SPAN_W{1'b0}}, v};
        if (w > {{OFFSET_BITS{1'b0}}, {SPAN_W{1'b1}}}) return {SPAN_W{1'b1}};
        return w[SPAN_W-1:0];
    endfunction

    function automatic token_t mk(input kind_t k, input logic [OFFSET_BITS-1:0] s,
                                  input logic [SPAN_W-1:0] sp, input logic [VAL_W-1:0] v,
                                  input err_t e, input logic [7:0] b);
        token_t t;
        t.token_kind   = k;
        t.start_offset = clip(s);
        t.span_length  = sp;
        t.int_value    = v;
        t.error_kind   = e;
        t.bad_char     = b;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    // Saturating digit accumulate: base 10 uses shift-add, base 16 a shift
    logic [VAL_W+4:0] mul10, mul16;
    logic [VAL_W+4:0] sum10, sum16;
    logic [VAL_W-1:0] dec_acc, hex_acc;
    logic [3:0]       dval;
    assign dval   = hex_val(c);
    assign mul10  = ({5'd0, acc} << 3) + ({5'd0, acc} << 1);
    assign mul16  = {5'd0, acc} << 4;
    assign sum10  = mul10 + {{(VAL_W+1){1'b0}}, dval};
    assign sum16  = mul16 + {{(VAL_W+1){1'b0}}, dval};
    assign dec_acc = (sum10 > {5'd0, VALUE_MAX}) ? VALUE_MAX : sum10[VAL_W-1:0];
    assign hex_acc = (sum16 > {5'd0, VALUE_MAX}) ? VALUE_MAX : sum16[VAL_W-1:0];

    logic [SPAN_W-1:0] span_inc;
    assign span_inc = (tspan != {SPAN_W{1'b1}}) ? tspan + 1'b1 : tspan;

    logic [OFFSET_BITS-1:0] tstart_inc;
    assign tstart_inc = (tstart != OFF_MAX) ? tstart + 1'b1 : tstart;

    localparam logic [SPAN_W-1:0]      SP0 = '0;
    localparam logic [SPAN_W-1:0]      SP1 = SPAN_W'(1);
    localparam logic [VAL_W-1:0]       V0  = '0;

    // Combinational next state and tokens
    always_comb
    begin
        logic      rescan;
        kind_t     pk;
        rescan      = 1'b0;
        mode_next   = mode;
        held_next   = held;
        tstart_next = tstart;
        tspan_next  = tspan;
        acc_next    = acc;
        boff_next   = (boff != OFF_MAX) ? boff + 1'b1 : boff;
        count       = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            tok[i] = '0;
        end
        pk = punct_kind(c);

        if (eot)
        begin
            // Flush pending token, then end of file
            case (mode)
                M_IDENT:  begin tok[0] = mk(K_IDENT, tstart, tspan, V0, E_NONE, 8'd0); count = 2'd1; end
                M_BUILTIN: begin tok[0] = mk(K_BUILTIN, tstart, tspan, V0, E_NONE, 8'd0); count = 2'd1; end
                M_AT:     begin tok[0] = mk(K_ERROR, tstart, SP0, V0, E_UNKNOWN, CH_AT); count = 2'd1; end
                M_STRING: begin tok[0] = mk(K_ERROR, tstart, SP0, V0, E_UNCLOSED, 8'd0); count = 2'd1; end
                M_ZERO:   begin tok[0] = mk(K_INT, tstart, SP1, V0, E_NONE, 8'd0); count = 2'd1; end
                M_ZERO_X:
                begin
                    tok[0] = mk(K_INT, tstart, SP1, V0, E_NONE, 8'd0);
                    tok[1] = mk(K_IDENT, tstart_inc, SP1, V0, E_NONE, 8'd0);
                    count = 2'd2;
                end
                M_HEX, M_DEC:
                begin
                    tok[0] = mk(K_INT, tstart, tspan, acc, E_NONE, 8'd0); count = 2'd1;
                end
                M_FLOAT:  begin tok[0] = mk(K_FLOAT, tstart, tspan, V0, E_NONE, 8'd0); count = 2'd1; end
                M_OP:     begin tok[0] = mk(single_kind(held), tstart, SP0, V0, E_NONE, 8'd0); count = 2'd1; end
                M_SHIFT:
                begin
                    tok[0] = mk((held == CH_LT) ? K_LSHIFT : K_RSHIFT, tstart, SP0, V0,
                                E_NONE, 8'd0);
                    count = 2'd1;
                end
                default: ;
            endcase
            tok[count] = mk(K_EOF, boff, SP0, V0, E_NONE, 8'd0);
            count = count + 2'd1;
            mode_next   = M_IDLE;
            held_next   = '0;
            boff_next   = '0;
            tstart_next = '0;
            tspan_next  = '0;
            acc_next    = '0;
        end
        else
        begin
            // Stage one: continue or finish the pending token
            case (mode)
                M_IDENT, M_BUILTIN:
                begin
                    if (is_alpha(c) || is_digit(c)) tspan_next = span_inc;
                    else
                    begin
                        tok[0] = mk((mode == M_IDENT) ? K_IDENT : K_BUILTIN, tstart, tspan,
                                    V0, E_NONE, 8'd0);
                        count = 2'd1; rescan = 1'b1;
                    end
                end
                M_AT:
                begin
                    if (is_alpha(c)) begin mode_next = M_BUILTIN; tspan_next = SP1; end
                    else
                    begin
                        tok[0] = mk(K_ERROR, tstart, SP0, V0, E_UNKNOWN, CH_AT);
                        count = 2'd1; rescan = 1'b1;
                    end
                end
                M_STRING:
                begin
                    if (c == CH_QUOTE)
                    begin
                        tok[0] = mk(K_STRING, tstart, tspan, V0, E_NONE, 8'd0);
                        count = 2'd1; mode_next = M_IDLE;
                    end
                    else tspan_next = span_inc;
                end
                M_ZERO:
                begin
                    if (c == CH_X) mode_next = M_ZERO_X;
                    else if (is_digit(c))
                    begin
                        mode_next = M_DEC; acc_next = {{(VAL_W-4){1'b0}}, dval};
                        tspan_next = SPAN_W'(2);
                    end
                    else if (c == CH_DOT) begin mode_next = M_FLOAT; tspan_next = SPAN_W'(2); end
                    else
                    begin
                        tok[0] = mk(K_INT, tstart, SP1, V0, E_NONE, 8'd0);
                        count = 2'd1; rescan = 1'b1;
                    end
                end
                M_ZERO_X:
                begin
                    if (is_hex(c))
                    begin
                        mode_next = M_HEX; acc_next = {{(VAL_W-4){1'b0}}, dval};
                        tspan_next = SP1;
                    end
                    else
                    begin
                        // "0x" with no digit: int 0, then identifier at the x
                        tok[0] = mk(K_INT, tstart, SP1, V0, E_NONE, 8'd0);
                        count = 2'd1;
                        if (is_alpha(c) || is_digit(c))
                        begin
                            mode_next = M_IDENT; tstart_next = tstart_inc;
                            tspan_next = SPAN_W'(2);
                        end
                        else
                        begin
                            tok[1] = mk(K_IDENT, tstart_inc, SP1, V0, E_NONE, 8'd0);
                            count = 2'd2; rescan = 1'b1;
                        end
                    end
                end
                M_HEX:
                begin
                    if (is_hex(c)) begin acc_next = hex_acc; tspan_next = span_inc; end
                    else
                    begin
                        tok[0] = mk(K_INT, tstart, tspan, acc, E_NONE, 8'd0);
                        count = 2'd1; rescan = 1'b1;
                    end
                end
                M_DEC:
                begin
                    if (is_digit(c)) begin acc_next = dec_acc; tspan_next = span_inc; end
                    else if (c == CH_DOT) begin mode_next = M_FLOAT; tspan_next = span_inc; end
                    else
                    begin
                        tok[0] = mk(K_INT, tstart, tspan, acc, E_NONE, 8'd0);
                        count = 2'd1; rescan = 1'b1;
                    end
                end
                M_FLOAT:
                begin
                    if (is_digit(c)) tspan_next = span_inc;
                    else
                    begin
                        tok[0] = mk(K_FLOAT, tstart, tspan, V0, E_NONE, 8'd0);
                        count = 2'd1; rescan = 1'b1;
                    end
                end
                M_OP:
                begin
                    if (c == CH_EQ)
                    begin
                        tok[0] = mk(assign_kind(held), tstart, SP0, V0, E_NONE, 8'd0);
                        count = 2'd1; mode_next = M_IDLE;
                    end
                    else if (c == held && (c == "<" || c == ">")) mode_next = M_SHIFT;
                    else if (c == held && (c == "+" || c == "-" || c == "|" || c == "&"))
                    begin
                        tok[0] = mk((c == "+") ? K_ADDADD : (c == "-") ? K_SUBSUB :
                                    (c == "|") ? K_OR : K_AND, tstart, SP0, V0, E_NONE, 8'd0);
                        count = 2'd1; mode_next = M_IDLE;
                    end
                    else
                    begin
                        tok[0] = mk(single_kind(held), tstart, SP0, V0, E_NONE, 8'd0);
                        count = 2'd1; rescan = 1'b1;
                    end
                end
                M_SHIFT:
                begin
                    if (c == CH_EQ)
                    begin
                        tok[0] = mk((held == CH_LT) ? K_LSHIFT_ASSIGN : K_RSHIFT_ASSIGN,
                                    tstart, SP0, V0, E_NONE, 8'd0);
                        count = 2'd1; mode_next = M_IDLE;
                    end
                    else
                    begin
                        tok[0] = mk((held == CH_LT) ? K_LSHIFT : K_RSHIFT, tstart, SP0, V0,
                                    E_NONE, 8'd0);
                        count = 2'd1; rescan = 1'b1;
                    end
                end
                default: rescan = 1'b1;
            endcase

            // Stage two: the byte opens a new token
            if (rescan)
            begin
                mode_next   = M_IDLE;
                tstart_next = boff;
                tspan_next  = '0;
                acc_next    = '0;
                if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) mode_next = M_IDLE;
                else if (c == CH_QUOTE) mode_next = M_STRING;
                else if (pk != K_ERROR)
                begin
                    tok[count] = mk(pk, boff, SP0, V0, E_NONE, 8'd0);
                    count = count + 2'd1;
                end
                else if (is_op(c)) begin held_next = c; mode_next = M_OP; end
                else if (c == CH_AT) mode_next = M_AT;
                else if (c == "0") begin mode_next = M_ZERO; tspan_next = SP1; end
                else if (is_alpha(c)) begin mode_next = M_IDENT; tspan_next = SP1; end
                else if (is_digit(c))
                begin
                    mode_next = M_DEC; tspan_next = SP1;
                    acc_next = {{(VAL_W-4){1'b0}}, dval};
                end
                else
                begin
                    tok[count] = mk(K_ERROR, boff, SP0, V0, E_UNKNOWN, c);
                    count = count + 2'd1;
                end
            end
        end
        if (count != 2'd0) tok[count - 2'd1].last_of_run = 1'b1;
    end

endmodule
`default_nettype wire

### dv/c_like_lexer_test.sv
// ----------------------------------------------------------------------------
// c_like_lexer_test
// Self-checking bench for the streaming lexer. Text bytes are fed from a
// queue by a clocked driver with random gaps. A model of the tokenizer
// predicts the tokens that each accepted byte completes. A clocked monitor
// stalls at random and checks every token against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module c_like_lexer_test;
    import cll_pkg::*;

    localparam int  RESET_CYCLES = 10;
    localparam int  IDLE_LIMIT   = 4000;
    localparam int  TAIL_CYCLES  = 20;
    localparam int  RANDOM_BEATS = 460;
    localparam int  PAUSE_AT     = 200;
    localparam logic [23:0] OFF_LIMIT = 24'hFFFFFF;
    localparam logic [62:0] SAT_VALUE = {63{1'b1}};

    logic clk;
    logic rst_n;

    cll_if #(.payload_t(text_t))  text_ch ();
    cll_if #(.payload_t(token_t)) tok_ch ();

    c_like_lexer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_ch),
        .token_out (tok_ch)
    );

    text_t     text_pending[$];
    token_t    tokens_due[$];
    int        err_count;
    int        beats_sent;
    int        idle_cycles;

    // Tokenizer state mirrored by the predictor
    lex_mode_t lx_mode;
    logic [7:0]  lx_op;
    logic [23:0] lx_off;
    logic [23:0] lx_start;
    logic [23:0] lx_span;
    logic [62:0] lx_acc;
    int          lx_emitted;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic bit letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit hexdig(input logic [7:0] c);
        return digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] hexnum(input logic [7:0] c);
        if (digit(c)) return 4'(c - "0");
        if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
        return 4'(c - "A" + 10);
    endfunction

    function automatic kind_t lone_op(input logic [7:0] op);
        case (op)
            "=": return K_ASSIGN;  "+": return K_ADD;    "-": return K_SUB;
            "*": return K_MUL;     "/": return K_DIV;    "%": return K_MOD;
            "|": return K_BITOR;   "&": return K_BITAND; "^": return K_BITXOR;
            "~": return K_BITNOT;  "!": return K_NOT;    "<": return K_LESS;
            default: return K_GREATER;
        endcase
    endfunction

    function automatic kind_t op_with_eq(input logic [7:0] op);
        case (op)
            "=": return K_EQ;            "+": return K_ADD_ASSIGN;
            "-": return K_SUB_ASSIGN;    "*": return K_MUL_ASSIGN;
            "/": return K_DIV_ASSIGN;    "%": return K_MOD_ASSIGN;
            "|": return K_BITOR_ASSIGN;  "&": return K_BITAND_ASSIGN;
            "^": return K_BITXOR_ASSIGN; "~": return K_BITNOT_ASSIGN;
            "!": return K_NOTEQ;         "<": return K_LESSEQ;
            default: return K_GREATEREQ;
        endcase
    endfunction

    task automatic clear_lexer();
        lx_mode  = M_IDLE;
        lx_op    = '0;
        lx_off   = '0;
        lx_start = '0;
        lx_span  = '0;
        lx_acc   = '0;
    endtask

    task automatic add_token(input kind_t k, input logic [23:0] st, input logic [23:0] sp,
                             input logic [62:0] v, input err_t e, input logic [7:0] bad);
        token_t t;
        if (lx_emitted < 3)
        begin
            t.token_kind   = k;
            t.start_offset = st;
            t.span_length  = sp;
            t.int_value    = v;
            t.error_kind   = e;
            t.bad_char     = bad;
            t.last_of_run  = 1'b0;
            tokens_due.push_back(t);
            lx_emitted++;
        end
    endtask

    task automatic grow();
        if (lx_span != OFF_LIMIT) lx_span++;
    endtask

    task automatic accumulate(input logic [63:0] base, input logic [63:0] d);
        logic [63:0] acc;
        acc = {1'b0, lx_acc};
        if (acc > ({1'b0, SAT_VALUE} - d) / base) lx_acc = SAT_VALUE;
        else lx_acc = 63'(acc * base + d);
    endtask

    task automatic open_token(input logic [7:0] c);
        lx_start = lx_off;
        lx_span  = '0;
        lx_acc   = '0;
        case (c)
            " ", 8'h09, 8'h0D, 8'h0A: ;
            CH_QUOTE: lx_mode = M_STRING;
            "{": add_token(K_LCURLY, lx_off, 0, 0, E_NONE, 0);
            "}": add_token(K_RCURLY, lx_off, 0, 0, E_NONE, 0);
            "[": add_token(K_LBRACKET, lx_off, 0, 0, E_NONE, 0);
            "]": add_token(K_RBRACKET, lx_off, 0, 0, E_NONE, 0);
            "(": add_token(K_LPAREN, lx_off, 0, 0, E_NONE, 0);
            ")": add_token(K_RPAREN, lx_off, 0, 0, E_NONE, 0);
            ":": add_token(K_COLON, lx_off, 0, 0, E_NONE, 0);
            ";": add_token(K_SEMICOLON, lx_off, 0, 0, E_NONE, 0);
            ".": add_token(K_DOT, lx_off, 0, 0, E_NONE, 0);
            ",": add_token(K_COMMA, lx_off, 0, 0, E_NONE, 0);
            "?": add_token(K_QUESTION, lx_off, 0, 0, E_NONE, 0);
            "=", "+", "-", "*", "/", "%", "|", "&", "^", "~", "!", "<", ">":
            begin
                lx_op   = c;
                lx_mode = M_OP;
            end
            CH_AT: lx_mode = M_AT;
            "0":
            begin
                lx_mode = M_ZERO;
                lx_span = 1;
            end
            default:
            begin
                if (letter(c))
                begin
                    lx_mode = M_IDENT;
                    lx_span = 1;
                end
                else if (digit(c))
                begin
                    lx_mode = M_DEC;
                    lx_span = 1;
                    lx_acc  = 63'(c - "0");
                end
                else
                    add_token(K_ERROR, lx_off, 0, 0, E_UNKNOWN, c);
            end
        endcase
    endtask

    // Bytes that end a token are scanned again from the idle state, or after a bare 0x as an identifier
    task automatic scan(input logic [7:0] c);
        bit again;
        again = 1'b1;
        while (again)
        begin
            again = 1'b0;
            case (lx_mode)
                M_IDLE: open_token(c);
                M_IDENT, M_BUILTIN:
                    if (letter(c) || digit(c)) grow();
                    else
                    begin
                        add_token(lx_mode == M_IDENT ? K_IDENT : K_BUILTIN,
                                  lx_start, lx_span, 0, E_NONE, 0);
                        lx_mode = M_IDLE;
                        again = 1'b1;
                    end
                M_AT:
                    if (letter(c))
                    begin
                        lx_mode = M_BUILTIN;
                        lx_span = 1;
                    end
                    else
                    begin
                        add_token(K_ERROR, lx_start, 0, 0, E_UNKNOWN, CH_AT);
                        lx_mode = M_IDLE;
                        again = 1'b1;
                    end
                M_STRING:
                    if (c == CH_QUOTE)
                    begin
                        add_token(K_STRING, lx_start, lx_span, 0, E_NONE, 0);
                        lx_mode = M_IDLE;
                    end
                    else grow();
                M_ZERO:
                    if (c == CH_X) lx_mode = M_ZERO_X;
                    else if (digit(c))
                    begin
                        lx_mode = M_DEC;
                        lx_acc  = 63'(c - "0");
                        lx_span = 2;
                    end
                    else if (c == CH_DOT)
                    begin
                        lx_mode = M_FLOAT;
                        lx_span = 2;
                    end
                    else
                    begin
                        add_token(K_INT, lx_start, 1, 0, E_NONE, 0);
                        lx_mode = M_IDLE;
                        again = 1'b1;
                    end
                M_ZERO_X:
                    if (hexdig(c))
                    begin
                        lx_mode = M_HEX;
                        lx_acc  = 63'(hexnum(c));
                        lx_span = 1;
                    end
                    else
                    begin
                        // the x starts an identifier
                        add_token(K_INT, lx_start, 1, 0, E_NONE, 0);
                        if (lx_start != OFF_LIMIT) lx_start++;
                        lx_span = 1;
                        lx_mode = M_IDENT;
                        again = 1'b1;
                    end
                M_HEX:
                    if (hexdig(c))
                    begin
                        accumulate(16, 64'(hexnum(c)));
                        grow();
                    end
                    else
                    begin
                        add_token(K_INT, lx_start, lx_span, lx_acc, E_NONE, 0);
                        lx_mode = M_IDLE;
                        again = 1'b1;
                    end
                M_DEC:
                    if (digit(c))
                    begin
                        accumulate(10, 64'(c - "0"));
                        grow();
                    end
                    else if (c == CH_DOT)
                    begin
                        lx_mode = M_FLOAT;
                        grow();
                    end
                    else
                    begin
                        add_token(K_INT, lx_start, lx_span, lx_acc, E_NONE, 0);
                        lx_mode = M_IDLE;
                        again = 1'b1;
                    end
                M_FLOAT:
                    if (digit(c)) grow();
                    else
                    begin
                        add_token(K_FLOAT, lx_start, lx_span, 0, E_NONE, 0);
                        lx_mode = M_IDLE;
                        again = 1'b1;
                    end
                M_OP:
                    if (c == CH_EQ)
                    begin
                        add_token(op_with_eq(lx_op), lx_start, 0, 0, E_NONE, 0);
                        lx_mode = M_IDLE;
                    end
                    else if (c == lx_op && (c == "<" || c == ">"))
                        lx_mode = M_SHIFT;
                    else if (c == lx_op && (c == "+" || c == "-" || c == "|" || c == "&"))
                    begin
                        add_token(c == "+" ? K_ADDADD : c == "-" ? K_SUBSUB :
                                  c == "|" ? K_OR : K_AND, lx_start, 0, 0, E_NONE, 0);
                        lx_mode = M_IDLE;
                    end
                    else
                    begin
                        add_token(lone_op(lx_op), lx_start, 0, 0, E_NONE, 0);
                        lx_mode = M_IDLE;
                        again = 1'b1;
                    end
                M_SHIFT:
                begin
                    if (c == CH_EQ)
                        add_token(lx_op == CH_LT ? K_LSHIFT_ASSIGN : K_RSHIFT_ASSIGN,
                                  lx_start, 0, 0, E_NONE, 0);
                    else
                    begin
                        add_token(lx_op == CH_LT ? K_LSHIFT : K_RSHIFT,
                                  lx_start, 0, 0, E_NONE, 0);
                        again = 1'b1;
                    end
                    lx_mode = M_IDLE;
                end
                default: lx_mode = M_IDLE;
            endcase
        end
    endtask

    task automatic flush_text();
        case (lx_mode)
            M_IDENT:   add_token(K_IDENT, lx_start, lx_span, 0, E_NONE, 0);
            M_BUILTIN: add_token(K_BUILTIN, lx_start, lx_span, 0, E_NONE, 0);
            M_AT:      add_token(K_ERROR, lx_start, 0, 0, E_UNKNOWN, CH_AT);
            M_STRING:  add_token(K_ERROR, lx_start, 0, 0, E_UNCLOSED, 0);
            M_ZERO:    add_token(K_INT, lx_start, 1, 0, E_NONE, 0);
            M_ZERO_X:
            begin
                add_token(K_INT, lx_start, 1, 0, E_NONE, 0);
                add_token(K_IDENT, lx_start != OFF_LIMIT ? lx_start + 24'd1 : lx_start,
                          1, 0, E_NONE, 0);
            end
            M_HEX, M_DEC: add_token(K_INT, lx_start, lx_span, lx_acc, E_NONE, 0);
            M_FLOAT:   add_token(K_FLOAT, lx_start, lx_span, 0, E_NONE, 0);
            M_OP:      add_token(lone_op(lx_op), lx_start, 0, 0, E_NONE, 0);
            M_SHIFT:   add_token(lx_op == CH_LT ? K_LSHIFT : K_RSHIFT,
                                 lx_start, 0, 0, E_NONE, 0);
            default: ;
        endcase
    endtask

    // Tokens that one accepted text beat completes
    task automatic predict_tokens(input text_t beat);
        lx_emitted = 0;
        if (beat.end_of_text)
        begin
            flush_text();
            add_token(K_EOF, lx_off, 0, 0, E_NONE, 0);
            clear_lexer();
        end
        else
        begin
            scan(beat.text_byte);
            if (lx_off != OFF_LIMIT) lx_off++;
        end
        if (lx_emitted > 0) tokens_due[$].last_of_run = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic put_byte(input logic [7:0] c);
        text_t b;
        b.text_byte   = c;
        b.end_of_text = 1'b0;
        text_pending.push_back(b);
    endtask

    task automatic put_end();
        text_t b;
        b.text_byte   = 8'($urandom);
        b.end_of_text = 1'b1;
        text_pending.push_back(b);
    endtask

    task automatic put_text(input string s);
        foreach (s[i]) put_byte(s[i]);
    endtask

    function automatic string pick_chars(input string set, input int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
        begin
            s = {s, " "};
            s.putc(s.len() - 1, set[$urandom_range(0, set.len() - 1)]);
        end
        return s;
    endfunction

    // One random lexeme, mostly well formed
    task automatic put_lexeme();
        string alpha;
        string alnum;
        string decs;
        string hexs;
        string ops;
        string punct;
        int    n;
        alpha = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
        alnum = {alpha, "0123456789"};
        decs  = "0123456789";
        hexs  = "0123456789abcdefABCDEF";
        ops   = "=+-*/%|&^~!<>";
        punct = "{}[]():;.,?";
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 4);
        case ($urandom_range(0, 15))
            0:  put_text({pick_chars(alpha, 1), pick_chars(alnum, $urandom_range(0, 5))});
            1:  put_text({"@", pick_chars(alpha, 1), pick_chars(alnum, $urandom_range(0, 4))});
            2:
            begin
                // string body from arbitrary bytes, never a quote
                put_byte(CH_QUOTE);
                repeat ($urandom_range(0, 5))
                begin
                    logic [7:0] c;
                    c = 8'($urandom);
                    if (c == CH_QUOTE) c = 8'hA2;
                    put_byte(c);
                end
                if ($urandom_range(0, 5) != 0) put_byte(CH_QUOTE);
            end
            3:  put_text({pick_chars("123456789", 1), pick_chars(decs, n)});
            4:  put_text({"0x", pick_chars(hexs, n)});
            5:  put_text({pick_chars(decs, $urandom_range(1, 3)), ".",
                          pick_chars(decs, $urandom_range(0, 3))});
            6:  put_text({"0", pick_chars("x.0123 ;a", 1)});
            7:  put_text({"0x", pick_chars("gxz_ (G", 1)});
            8, 9: put_text({pick_chars(ops, 1), pick_chars({ops, "=a1 "}, 1)});
            10:
            begin
                if ($urandom_range(0, 1) == 0) put_text("<<");
                else put_text(">>");
                put_text(pick_chars("=< 1", 1));
            end
            11: put_text(pick_chars(punct, 1));
            12: put_text(pick_chars(" \t\r\n", $urandom_range(1, 3)));
            13: put_byte(8'($urandom));
            14: put_text({"@", pick_chars("@1 +", 1)});
            default:
                if ($urandom_range(0, 2) == 0) put_end();
                else put_text(" ");
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------------
    int  send_gap;
    int  send_burst;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (text_ch.valid && text_ch.ready)
            begin
                predict_tokens(text_ch.data);
                beats_sent++;
            end
            if (text_ch.valid && !text_ch.ready)
                ;
            else if (send_gap > 0)
            begin
                send_gap--;
                text_ch.valid <= 1'b0;
            end
            else if ((beats_sent == PAUSE_AT && tokens_due.size() != 0)
                     || text_pending.size() == 0)
                text_ch.valid <= 1'b0;
            else
            begin
                text_ch.valid <= 1'b1;
                text_ch.data  <= text_pending.pop_front();
                if (send_burst > 0) send_burst--;
                else if ($urandom_range(0, 40) == 0) send_burst = $urandom_range(10, 40);
                else send_gap = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------------
    int stall;

    task automatic report(input string field, input logic [63:0] got,
                          input logic [63:0] want);
        $display("%0t: token %s mismatch: got %0h expected %0h", $realtime, field, got, want);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        token_t want;
        token_t got;
        if (rst_n)
        begin
            if (tok_ch.valid && tok_ch.ready)
            begin
                got = tok_ch.data;
                if (tokens_due.size() == 0)
                begin
                    $display("%0t: token with no prediction, kind %0d", $realtime,
                             got.token_kind);
                    err_count++;
                end
                else
                begin
                    want = tokens_due.pop_front();
                    if (got.token_kind !== want.token_kind)
                        report("kind", got.token_kind, want.token_kind);
                    if (got.start_offset !== want.start_offset)
                        report("start", got.start_offset, want.start_offset);
                    if (got.span_length !== want.span_length)
                        report("span", got.span_length, want.span_length);
                    if (got.int_value !== want.int_value)
                        report("value", got.int_value, want.int_value);
                    if (got.error_kind !== want.error_kind)
                        report("error", got.error_kind, want.error_kind);
                    if (got.bad_char !== want.bad_char)
                        report("bad_char", got.bad_char, want.bad_char);
                    if (got.last_of_run !== want.last_of_run)
                        report("last", got.last_of_run, want.last_of_run);
                end
            end
            if (stall > 0)
            begin
                stall--;
                tok_ch.ready <= 1'b0;
            end
            else
            begin
                tok_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall = pick_gap();
            end
        end
    end

    // Watchdog on beats in either direction
    always @(posedge clk)
    begin
        if ((text_ch.valid && text_ch.ready) || (tok_ch.valid && tok_ch.ready))
            idle_cycles <= 0;
        else if (rst_n)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        text_ch.valid = 1'b0;
        text_ch.data  = '0;
        tok_ch.ready  = 1'b0;
        err_count   = 0;
        beats_sent  = 0;
        idle_cycles = 0;
        send_gap    = 0;
        send_burst  = 0;
        stall       = 0;
        clear_lexer();
        rst_n = 1'b0;

        // directed: lone @, 0x without digit, shifts with '=', float, unclosed string
        put_text("a@1 0xg<<=>>=7.5 @");
        put_byte(8'hFF);
        put_text("\"q");
        put_end();
        put_text("0x");
        put_end();
        while (text_pending.size() < RANDOM_BEATS) put_lexeme();
        put_end();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (text_pending.size() != 0 || text_ch.valid || tokens_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0 && tokens_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire

### c_like_lexer.f
+incdir+design
design/cll_pkg.sv
design/cll_if.sv
design/cll_step.sv
design/c_like_lexer.sv
dv/c_like_lexer_test.sv
